/* rtl/dnd_pkg.sv */
// shared types and constants for the dns name decompressor
package dnd_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_PARSE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] LABEL_LIMIT = 8'd64;
    localparam logic [7:0] PTR_MARK    = 8'hC0;
    localparam int         PTR_BITS    = 14;
    localparam logic [7:0] DOT_CHAR    = 8'h2E;

    typedef struct packed {
        logic load;
        logic read;
        logic bad;
        logic init;
        logic fail;
        logic finish;
        logic label;
        logic copy;
        logic dot;
        logic ptr;
        logic jump;
    } t_cmd;

    typedef struct packed {
        logic start_ok;
        logic at_end;
        logic is_zero;
        logic is_label;
        logic label_ok;
        logic is_ptr;
        logic hop_ok;
        logic tgt_ok;
        logic cnt_last;
    } t_sts;

endpackage

/* rtl/dnd_ctrl.sv */
// parse sequencer for the dns name decompressor
module dnd_ctrl
    import dnd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_op,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_COPY = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_PTR  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_LOAD: o_cmd.load = 1'b1;
                        OP_READ: o_cmd.read = 1'b1;
                        OP_PARSE: begin
                            if (i_sts.start_ok) begin
                                o_cmd.init = 1'b1;
                                n_state    = S_EVAL;
                            end else begin
                                o_cmd.fail = 1'b1;
                            end
                        end
                        default: o_cmd.bad = 1'b1;
                    endcase
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (i_sts.at_end) begin
                    o_cmd.fail = 1'b1;
                end else if (i_sts.is_zero) begin
                    o_cmd.finish = 1'b1;
                end else if (i_sts.is_label) begin
                    if (i_sts.label_ok) begin
                        o_cmd.label = 1'b1;
                        n_state     = S_COPY;
                    end else begin
                        o_cmd.fail = 1'b1;
                    end
                end else if (i_sts.is_ptr && i_sts.hop_ok) begin
                    o_cmd.ptr = 1'b1;
                    n_state   = S_PTR;
                end else begin
                    o_cmd.fail = 1'b1;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                o_cmd.dot = 1'b1;
                n_state   = S_EVAL;
            end
            S_PTR: begin
                if (i_sts.tgt_ok) begin
                    o_cmd.jump = 1'b1;
                    n_state    = S_EVAL;
                end else begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

/* rtl/dnd_dpath.sv */
// message store, name store and walk registers of the dns name decompressor
module dnd_dpath
    import dnd_pkg::*;
#(
    parameter int MSG_BYTES  = 512,
    parameter int NAME_BYTES = 256,
    parameter int MAX_HOPS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic [8:0] i_byte_addr,
    input  logic [7:0] i_data_byte,
    input  logic [9:0] i_msg_length,
    output t_sts       o_sts,
    output logic       o_done,
    output logic       o_status,
    output logic [9:0] o_end_offset,
    output logic [7:0] o_name_length,
    output logic [7:0] o_name_byte
);

    localparam int LW = $clog2(MSG_BYTES + 1);
    localparam int MA = $clog2(MSG_BYTES);
    localparam int NA = $clog2(NAME_BYTES);
    localparam int NW = $clog2(NAME_BYTES + 1);
    localparam int HW = $clog2(MAX_HOPS + 1);
    localparam int CW = (LW > PTR_BITS) ? LW + 1 : PTR_BITS + 1;

    logic [7:0]          r_msg [MSG_BYTES];
    logic [7:0]          r_name [NAME_BYTES];
    logic [7:0]          r_rd;
    logic [7:0]          r_nrd;
    logic [LW-1:0]       r_pos;
    logic [LW-1:0]       n_pos;
    logic [LW-1:0]       r_len;
    logic [NW-1:0]       r_written;
    logic [HW-1:0]       r_hops;
    logic                r_jumped;
    logic [LW-1:0]       r_first_end;
    logic [5:0]          r_cnt;
    logic [5:0]          r_hi;
    logic                r_done;
    logic                r_status;
    logic [9:0]          r_end;
    logic [7:0]          r_dlen;
    logic                r_nb_ok;

    logic [CW-1:0]       w_addr_x;
    logic [CW-1:0]       w_mlen_x;
    logic [CW-1:0]       w_pos_x;
    logic [CW-1:0]       w_len_x;
    logic [LW-1:0]       w_len_sat;
    logic [PTR_BITS-1:0] w_target;
    logic                w_rd_ok;
    logic                w_name_wr;

    assign w_addr_x  = CW'(i_byte_addr);
    assign w_mlen_x  = CW'(i_msg_length);
    assign w_len_sat = (w_mlen_x > CW'(MSG_BYTES)) ? LW'(MSG_BYTES) : LW'(w_mlen_x);
    assign w_pos_x   = CW'(r_pos);
    assign w_len_x   = CW'(r_len);
    assign w_target  = {r_hi, r_rd};
    assign w_rd_ok   = w_addr_x < CW'(r_dlen);
    assign w_name_wr = i_cmd.copy | i_cmd.dot;

    always_comb begin
        o_sts          = '0;
        o_sts.start_ok = w_addr_x < CW'(w_len_sat);
        o_sts.at_end   = w_pos_x >= w_len_x;
        o_sts.is_zero  = (r_rd == 8'd0);
        o_sts.is_label = (r_rd != 8'd0) && (r_rd < LABEL_LIMIT);
        o_sts.label_ok = ((w_pos_x + CW'(r_rd)) < w_len_x)
                      && ((CW'(r_rd) + CW'(r_written)) < CW'(NAME_BYTES));
        o_sts.is_ptr   = ((r_rd & PTR_MARK) == PTR_MARK) && ((w_pos_x + CW'(1)) < w_len_x);
        o_sts.hop_ok   = CW'(r_hops) < CW'(MAX_HOPS);
        o_sts.tgt_ok   = CW'(w_target) < w_len_x;
        o_sts.cnt_last = (r_cnt == 6'd1);
    end

    always_comb begin
        n_pos = r_pos;
        if (i_cmd.init) begin
            n_pos = LW'(w_addr_x);
        end else if (i_cmd.label || i_cmd.copy || i_cmd.ptr) begin
            n_pos = r_pos + LW'(1);
        end else if (i_cmd.jump) begin
            n_pos = LW'(w_target);
        end
    end

    // message store: the read port follows the next walk position
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (w_addr_x < CW'(MSG_BYTES))) begin
            r_msg[w_addr_x[MA-1:0]] <= i_data_byte;
        end
        r_rd <= r_msg[n_pos[MA-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_name_wr) begin
            r_name[r_written[NA-1:0]] <= i_cmd.dot ? DOT_CHAR : r_rd;
        end
        if (i_cmd.read) begin
            r_nrd <= r_name[i_byte_addr[NA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (i_cmd.init) begin
            r_len     <= w_len_sat;
            r_written <= '0;
            r_hops    <= '0;
            r_jumped  <= 1'b0;
        end
        if (i_cmd.label) begin
            r_cnt <= r_rd[5:0];
        end
        if (i_cmd.copy) begin
            r_cnt <= r_cnt - 6'd1;
        end
        if (w_name_wr) begin
            r_written <= r_written + NW'(1);
        end
        if (i_cmd.ptr) begin
            r_hops <= r_hops + HW'(1);
            r_hi   <= r_rd[5:0];
            if (!r_jumped) begin
                r_jumped    <= 1'b1;
                r_first_end <= r_pos + LW'(2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_dlen <= 8'd0;
        end else begin
            r_done <= i_cmd.load | i_cmd.read | i_cmd.bad | i_cmd.fail | i_cmd.finish;
            if (i_cmd.fail) begin
                r_dlen <= 8'd0;
            end else if (i_cmd.finish) begin
                r_dlen <= (r_written == '0) ? 8'd0 : 8'(r_written - NW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= i_cmd.bad | i_cmd.fail | (i_cmd.read & ~w_rd_ok);
        r_nb_ok  <= i_cmd.read & w_rd_ok;
        if (i_cmd.finish) begin
            r_end <= r_jumped ? 10'(r_first_end) : 10'(r_pos + LW'(1));
        end else begin
            r_end <= 10'd0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_end_offset  = r_end;
    assign o_name_length = r_dlen;
    assign o_name_byte   = r_nb_ok ? r_nrd : 8'd0;

endmodule

/* rtl/dns_name_decompressor.sv */
// top level of the dns name decompressor
// load, read and unused ops give their result in the cycle after the command beat
// a parse walks each label through eval, copy once per label byte and dot, each pointer
// through eval and ptr, and ends in eval; busy is high while the walk sequencer runs
// the single message store read port, one byte per cycle, sets the walk speed
// reset clears the sequencer, the result strobe and the name length; stores keep contents
module dns_name_decompressor
    import dnd_pkg::*;
#(
    parameter int MSG_BYTES  = 512,
    parameter int NAME_BYTES = 256,
    parameter int MAX_HOPS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_op,
    input  logic [8:0] i_byte_addr,
    input  logic [7:0] i_data_byte,
    input  logic [9:0] i_msg_length,
    output logic       o_done,
    output logic       o_status,
    output logic [9:0] o_end_offset,
    output logic [7:0] o_name_length,
    output logic [7:0] o_name_byte
);

    t_cmd w_cmd;
    t_sts w_sts;

    dnd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    dnd_dpath #(
        .MSG_BYTES  (MSG_BYTES),
        .NAME_BYTES (NAME_BYTES),
        .MAX_HOPS   (MAX_HOPS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_byte_addr   (i_byte_addr),
        .i_data_byte   (i_data_byte),
        .i_msg_length  (i_msg_length),
        .o_sts         (w_sts),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_end_offset  (o_end_offset),
        .o_name_length (o_name_length),
        .o_name_byte   (o_name_byte)
    );

    a_quick_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op != OP_PARSE)) |=> (o_done && !busy))
        else $error("single-cycle command gave no result beat");

    a_parse_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_PARSE)) |=> (busy || o_done))
        else $error("parse command neither started nor reported");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while the walk is still running");

    a_end_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_end_offset != 10'd0)) |-> !o_status)
        else $error("end offset reported on a failed beat");

    a_byte_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_name_byte == 8'd0))
        else $error("name byte reported on a failed beat");

endmodule
